FILE: hw/rtl/key_matrix_to_hid_with_hotkey_unit_defines.svh
// Assertion macros for the key matrix to HID block.
// Taken in by the top level through an include of this header.
`ifndef KEY_MATRIX_TO_HID_WITH_HOTKEY_UNIT_DEFINES_SVH
`define KEY_MATRIX_TO_HID_WITH_HOTKEY_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMH_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/kmh_pkg.sv
// Shared types, codes and key tables for the key matrix to HID block.
// No dependencies; imported by every module of the block.
package kmh_pkg;

   localparam int KEY_COUNT   = 35;
   localparam int REPORT_KEYS = 6;
   localparam int TIME_W      = 48;
   localparam int TAP_US_W    = 23;
   localparam int CMD_US_W    = 26;
   localparam int SLOTS       = 10;

   // Key positions inside a snapshot
   localparam int BIT_SYM    = 2;
   localparam int BIT_ALT    = 4;
   localparam int BIT_LSHIFT = 13;
   localparam int BIT_RSHIFT = 17;

   // Symbol, Alt, Mic and both Shift keys
   localparam logic [KEY_COUNT-1:0] SKIP_MASK = 35'h0_0002_2054;

   localparam logic [9:0] MS_TO_US = 10'd1000;

   typedef enum logic [1:0] {
      HK_IDLE   = 2'd0,
      HK_TAPPED = 2'd1,
      HK_CMD    = 2'd2
   } hk_mode_type;

   typedef enum logic [2:0] {
      ACT_REPORT         = 3'd0,
      ACT_DIRECT         = 3'd1,
      ACT_CHORD_ENTERED  = 3'd2,
      ACT_CHORD_WAIT     = 3'd3,
      ACT_CHORD_SWITCHED = 3'd4,
      ACT_EMPTY_SLOT     = 3'd5,
      ACT_CANCELLED      = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      CSR_TAP_WINDOW = 2'd0,
      CSR_CMD_TIMEOUT = 2'd1,
      CSR_PAIRED     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [34:0] matrix;
      logic [47:0] time_us;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  slot;
      logic        entered_command;
      logic [1:0]  modifiers;
      logic [7:0]  key_0;
      logic [7:0]  key_1;
      logic [7:0]  key_2;
      logic [7:0]  key_3;
      logic [7:0]  key_4;
      logic [7:0]  key_5;
   } rsp_type;

   // Settings handed from the register file, times already in microseconds
   typedef struct packed {
      logic [TAP_US_W-1:0] tap_us;
      logic [CMD_US_W-1:0] cmd_us;
      logic [SLOTS-1:0]    paired;
   } cfg_type;

   // Per-snapshot key scan summary
   typedef struct packed {
      logic [KEY_COUNT-1:0] new_onehot;
      logic                 new_any;
      logic                 digit_ok;
      logic [3:0]           digit;
      logic                 slot_ok;
      logic [3:0]           slot;
      logic                 shift;
      logic [5:0][7:0]      keys;
      logic [KEY_COUNT-1:0] kept;
   } scan_type;

   // Usage in bits 7:0, bit 8 set when the character needs Shift
   localparam logic [8:0] PLAIN_TAB [KEY_COUNT] = '{
      9'h014, 9'h01A, 9'h000, 9'h004, 9'h000, 9'h02C, 9'h000,
      9'h008, 9'h016, 9'h007, 9'h013, 9'h01B, 9'h01D, 9'h000,
      9'h015, 9'h00A, 9'h017, 9'h000, 9'h019, 9'h006, 9'h009,
      9'h018, 9'h00B, 9'h01C, 9'h028, 9'h005, 9'h011, 9'h00D,
      9'h012, 9'h00F, 9'h00C, 9'h02A, 9'h121, 9'h010, 9'h00E
   };

   localparam logic [8:0] SYM_TAB [KEY_COUNT] = '{
      9'h120, 9'h01E, 9'h000, 9'h125, 9'h000, 9'h000, 9'h027,
      9'h01F, 9'h021, 9'h022, 9'h11F, 9'h025, 9'h024, 9'h000,
      9'h020, 9'h038, 9'h126, 9'h000, 9'h138, 9'h026, 9'h023,
      9'h12D, 9'h133, 9'h127, 9'h028, 9'h11E, 9'h036, 9'h033,
      9'h12E, 9'h134, 9'h02D, 9'h02A, 9'h000, 9'h037, 9'h034
   };

   // Bit 4 marks an entry, bits 3:0 the digit or slot
   localparam logic [4:0] DIGIT_TAB [KEY_COUNT] = '{
      5'h00, 5'h11, 5'h00, 5'h00, 5'h00, 5'h00, 5'h10,
      5'h12, 5'h14, 5'h15, 5'h00, 5'h18, 5'h17, 5'h00,
      5'h13, 5'h00, 5'h00, 5'h00, 5'h00, 5'h19, 5'h16,
      5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
      5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00
   };

   localparam logic [4:0] SLOT_TAB [KEY_COUNT] = '{
      5'h10, 5'h11, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
      5'h12, 5'h00, 5'h00, 5'h19, 5'h00, 5'h00, 5'h00,
      5'h13, 5'h00, 5'h14, 5'h00, 5'h00, 5'h00, 5'h00,
      5'h16, 5'h00, 5'h15, 5'h00, 5'h00, 5'h00, 5'h00,
      5'h18, 5'h00, 5'h17, 5'h00, 5'h00, 5'h00, 5'h00
   };

endpackage

FILE: hw/rtl/kmh_csr.sv
// Configuration registers behind an APB-style port.
// Depends on kmh_pkg; also keeps the windows converted to microseconds.
module kmh_csr
   import kmh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [12:0]         tap_ms_ff, tap_ms_in;
   logic [15:0]         cmd_ms_ff, cmd_ms_in;
   logic [SLOTS-1:0]    paired_ff, paired_in;
   logic [TAP_US_W-1:0] tap_us_ff, tap_us_in;
   logic [CMD_US_W-1:0] cmd_us_ff, cmd_us_in;
   logic                wr_en;
   csr_index_type       wr_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_idx     = csr_index_type'(csr_paddr[3:2]);

   // Decode the write and convert ms to us at write time
   always_comb begin
      tap_ms_in = tap_ms_ff;
      cmd_ms_in = cmd_ms_ff;
      paired_in = paired_ff;
      tap_us_in = tap_us_ff;
      cmd_us_in = cmd_us_ff;
      if (wr_en) begin
         case (wr_idx)
            CSR_TAP_WINDOW: begin
               tap_ms_in = csr_pwdata[12:0];
               tap_us_in = TAP_US_W'(csr_pwdata[12:0] * MS_TO_US);
            end
            CSR_CMD_TIMEOUT: begin
               cmd_ms_in = csr_pwdata[15:0];
               cmd_us_in = CMD_US_W'(csr_pwdata[15:0] * MS_TO_US);
            end
            CSR_PAIRED: paired_in = csr_pwdata[SLOTS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ms_ff <= 13'd300;
         cmd_ms_ff <= 16'd3000;
         paired_ff <= '0;
         tap_us_ff <= TAP_US_W'(300000);
         cmd_us_ff <= CMD_US_W'(3000000);
      end else begin
         tap_ms_ff <= tap_ms_in;
         cmd_ms_ff <= cmd_ms_in;
         paired_ff <= paired_in;
         tap_us_ff <= tap_us_in;
         cmd_us_ff <= cmd_us_in;
      end
   end

   // Read back
   always_comb begin
      case (wr_idx)
         CSR_TAP_WINDOW:  csr_prdata = {19'd0, tap_ms_ff};
         CSR_CMD_TIMEOUT: csr_prdata = {16'd0, cmd_ms_ff};
         CSR_PAIRED:      csr_prdata = {22'd0, paired_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.tap_us = tap_us_ff;
   assign cfg.cmd_us = cmd_us_ff;
   assign cfg.paired = paired_ff;

endmodule

FILE: hw/rtl/kmh_keyscan.sv
// Per-key scan of one snapshot: first new press, its digit and slot,
// the six-usage report and the swallow mask update. Depends on kmh_pkg.
module kmh_keyscan
   import kmh_pkg::*;
(
   input  logic [KEY_COUNT-1:0] raw,
   input  logic [KEY_COUNT-1:0] prev,
   input  logic [KEY_COUNT-1:0] swallowed,
   output scan_type             scan
);

   logic [7:0]           code [KEY_COUNT];
   logic [KEY_COUNT-1:0] shift_char;
   logic [KEY_COUNT-1:0] has_code;
   logic [KEY_COUNT-1:0] usable;
   logic [KEY_COUNT-1:0] fresh;
   logic [KEY_COUNT-1:0] first;
   logic [5:0]           rank [KEY_COUNT];
   logic                 sym_layer;

   assign sym_layer = raw[BIT_SYM];

   // Pick the layer for each position
   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         code[i]       = sym_layer ? SYM_TAB[i][7:0] : PLAIN_TAB[i][7:0];
         shift_char[i] = sym_layer ? SYM_TAB[i][8] : PLAIN_TAB[i][8];
         has_code[i]   = code[i] != 8'd0;
      end
   end

   assign usable = raw & ~SKIP_MASK & ~swallowed & has_code;
   assign fresh  = raw & ~prev & ~SKIP_MASK & ~swallowed;
   // Isolate the lowest newly pressed key
   assign first  = fresh & (~fresh + KEY_COUNT'(1));

   // Place of each usable key among those before it
   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         rank[i] = 6'($countones(usable & ((KEY_COUNT'(1) << i) - KEY_COUNT'(1))));
      end
   end

   // Gather usages, lookups and modifiers
   always_comb begin
      logic [4:0] dig;
      logic [4:0] slt;
      dig = '0;
      slt = '0;
      scan.shift = 1'b0;
      scan.keys  = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (first[i]) begin
            dig = dig | DIGIT_TAB[i];
            slt = slt | SLOT_TAB[i];
         end
         if (usable[i] && rank[i] < 6'(REPORT_KEYS) && shift_char[i]) begin
            scan.shift = 1'b1;
         end
      end
      for (int k = 0; k < REPORT_KEYS; k++) begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            if (usable[i] && rank[i] == 6'(k)) begin
               scan.keys[k] = scan.keys[k] | code[i];
            end
         end
      end
      scan.new_onehot = first;
      scan.new_any    = |fresh;
      scan.digit_ok   = dig[4];
      scan.digit      = dig[3:0];
      scan.slot_ok    = slt[4];
      scan.slot       = slt[3:0];
      // Drop swallowed keys once released
      scan.kept       = swallowed & raw;
   end

endmodule

FILE: hw/rtl/key_matrix_to_hid_with_hotkey_unit.sv
// Top level: key matrix snapshots to HID reports with the Alt double-tap hotkey.
// Depends on kmh_pkg, kmh_csr, kmh_keyscan and the block's assertion header.
//
//   port group  | direction | transfer
//   req_*       | in        | one snapshot: matrix, time_us
//   rsp_*       | out       | zero or one result per snapshot
//   csr_*       | in/out    | APB-style register writes and reads
//
// One snapshot per cycle sustained while results are taken: input register, one
// pass of key scan and hotkey logic, result register. A result is offered from the
// result register once its snapshot has passed the input register and the logic.
// A snapshot that changes nothing outside command mode is consumed silently.
// A stalled result holds the input register; req_ready follows that stall.
// Synchronous reset clears the hotkey state, the snapshot history and both
// valid flags; no clearing pass.
`include "key_matrix_to_hid_with_hotkey_unit_defines.svh"

module key_matrix_to_hid_with_hotkey_unit
   import kmh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type  cfg;
   scan_type scan;

   logic                 in_valid_ff, in_valid_in;
   req_type              in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_data_ff, rsp_in;

   hk_mode_type          mode_ff, mode_in, mode_a, mode_exp;
   logic [TIME_W-1:0]    tap_start_ff, tap_start_in;
   logic [TIME_W-1:0]    armed_dl_ff, armed_dl_in;
   logic [TIME_W-1:0]    cmd_dl_ff, cmd_dl_in, cmd_dl_a;
   logic                 okih_ff, okih_in, okih_a;
   logic [KEY_COUNT-1:0] last_ff, last_in;
   logic [KEY_COUNT-1:0] swal_ff, swal_in;

   logic [KEY_COUNT-1:0] raw;
   logic [TIME_W-1:0]    now;
   logic                 proc_go, quiet, alt_held, alt_chg, shift_held;
   logic                 entered, direct, bare;
   logic [TIME_W:0]      armed_sum, cmd_sum;
   logic [TIME_W-1:0]    armed_sat, cmd_sat, elapsed;

   kmh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign raw = in_data_ff.matrix;
   assign now = in_data_ff.time_us;

   kmh_keyscan u_scan (
      .raw       (raw),
      .prev      (last_ff),
      .swallowed (swal_ff),
      .scan      (scan)
   );

   // Handshake: process when the result register is free or draining
   assign proc_go   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_go;

   assign quiet      = (raw == last_ff) && (mode_ff != HK_CMD);
   assign alt_held   = raw[BIT_ALT];
   assign alt_chg    = raw[BIT_ALT] != last_ff[BIT_ALT];
   assign shift_held = raw[BIT_LSHIFT] || raw[BIT_RSHIFT];

   // Deadlines saturate at the top of the time range
   assign armed_sum = {1'b0, now} + (TIME_W+1)'(cfg.tap_us);
   assign cmd_sum   = {1'b0, now} + (TIME_W+1)'(cfg.cmd_us);
   assign armed_sat = armed_sum[TIME_W] ? '1 : armed_sum[TIME_W-1:0];
   assign cmd_sat   = cmd_sum[TIME_W] ? '1 : cmd_sum[TIME_W-1:0];

   // Time running backwards counts as no time
   assign elapsed  = (now >= tap_start_ff) ? (now - tap_start_ff) : '0;
   assign bare     = !okih_ff && (elapsed < TIME_W'(cfg.tap_us));
   assign mode_exp = (mode_ff == HK_TAPPED && now > armed_dl_ff) ? HK_IDLE : mode_ff;

   // Next state of the hotkey machine
   always_comb begin
      mode_a       = mode_ff;
      entered      = 1'b0;
      tap_start_in = tap_start_ff;
      okih_a       = okih_ff;
      armed_dl_in  = armed_dl_ff;
      cmd_dl_a     = cmd_dl_ff;
      if (alt_chg) begin
         mode_a = mode_exp;
         if (alt_held) begin
            if (mode_exp == HK_TAPPED) begin
               mode_a   = HK_CMD;
               cmd_dl_a = cmd_sat;
               entered  = 1'b1;
            end else begin
               tap_start_in = now;
               okih_a       = 1'b0;
            end
         end else if (bare && mode_exp == HK_IDLE) begin
            mode_a      = HK_TAPPED;
            armed_dl_in = armed_sat;
         end else begin
            mode_a = HK_IDLE;
         end
      end

      direct  = alt_held && scan.new_any && scan.slot_ok && cfg.paired[scan.slot];
      okih_in = (alt_held && scan.new_any) ? 1'b1 : okih_a;
      cmd_dl_in = cmd_dl_a;

      mode_in = mode_a;
      if (!direct && mode_a == HK_CMD) begin
         if (scan.new_any || now > cmd_dl_a) begin
            mode_in = HK_IDLE;
         end
      end

      last_in = raw;
      swal_in = scan.kept | (direct ? scan.new_onehot : '0);
   end

   // Result of this snapshot
   always_comb begin
      rsp_in = '0;
      rsp_in.entered_command = entered;
      if (direct) begin
         rsp_in.action = ACT_DIRECT;
         rsp_in.slot   = scan.slot;
      end else if (mode_a == HK_CMD) begin
         if (scan.new_any) begin
            if (scan.digit_ok && cfg.paired[scan.digit]) begin
               rsp_in.action = ACT_CHORD_SWITCHED;
               rsp_in.slot   = scan.digit;
            end else if (scan.digit_ok) begin
               rsp_in.action = ACT_EMPTY_SLOT;
            end else begin
               rsp_in.action = ACT_CANCELLED;
            end
         end else if (now > cmd_dl_a) begin
            rsp_in.action = ACT_CANCELLED;
         end else begin
            rsp_in.action = entered ? ACT_CHORD_ENTERED : ACT_CHORD_WAIT;
         end
      end else begin
         rsp_in.action    = ACT_REPORT;
         rsp_in.modifiers = {shift_held || scan.shift, alt_held};
         rsp_in.key_0     = scan.keys[0];
         rsp_in.key_1     = scan.keys[1];
         rsp_in.key_2     = scan.keys[2];
         rsp_in.key_3     = scan.keys[3];
         rsp_in.key_4     = scan.keys[4];
         rsp_in.key_5     = scan.keys[5];
      end
   end

   // Valid flags: fill on transfer, drain on processing or delivery
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (proc_go) begin
         out_valid_in = !quiet;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= HK_IDLE;
         tap_start_ff <= '0;
         armed_dl_ff  <= '0;
         cmd_dl_ff    <= '0;
         okih_ff      <= 1'b0;
         last_ff      <= '0;
         swal_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // Advance hotkey state only on a snapshot that does something
         if (proc_go && !quiet) begin
            mode_ff      <= mode_in;
            tap_start_ff <= tap_start_in;
            armed_dl_ff  <= armed_dl_in;
            cmd_dl_ff    <= cmd_dl_in;
            okih_ff      <= okih_in;
            last_ff      <= last_in;
            swal_ff      <= swal_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (proc_go && !quiet) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks on the block's own logic
   `KMH_ASSERT_NOW(a_non_report_clean, clock, reset, rsp_valid && rsp_data.action != ACT_REPORT, rsp_data.modifiers == 2'd0 && rsp_data.key_0 == 8'd0 && rsp_data.key_5 == 8'd0, "non-report result carries report data")
   `KMH_ASSERT_NOW(a_slot_only_switch, clock, reset, rsp_valid && rsp_data.action != ACT_DIRECT && rsp_data.action != ACT_CHORD_SWITCHED, rsp_data.slot == 4'd0, "slot set without a switch")
   `KMH_ASSERT_NOW(a_entered_action, clock, reset, rsp_valid && rsp_data.entered_command, rsp_data.action != ACT_REPORT && rsp_data.action != ACT_CHORD_WAIT, "command entry with report or wait action")
   `KMH_ASSERT_NEXT(a_history_tracks, clock, reset, proc_go && !quiet, last_ff == $past(in_data_ff.matrix) && out_valid_ff, "snapshot history or result lost")

endmodule
